[hw/rtl/hce_pkg.sv]
// ----------------------------------------------------------------------------
// hce_pkg
// Shared types, constants and the modulo-26 reduction for the Hill cipher
// encryption unit.
// ----------------------------------------------------------------------------
package hce_pkg;

  localparam int LETTER_W    = 5;
  localparam int ROW_ENTRIES = 4;
  localparam int ROW_W       = ROW_ENTRIES * LETTER_W;
  localparam int IDX_W       = 2;
  localparam int SIZE_W      = 3;
  localparam int PROD_W      = 2 * LETTER_W;
  localparam int SUM_W       = 12;
  localparam int CFG_IDX_W   = 3;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] REG_KEY_SIZE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW_3 = 3'd4;

  localparam logic [6:0] ALPHABET   = 7'd26;
  localparam logic [6:0] ALPHABET_2 = 7'd52;

  // (h * 256) mod 26 and (h * 16) mod 26 for a 4-bit digit h.
  localparam logic [LETTER_W-1:0] TAB_HI [16] = '{
    5'd0, 5'd22, 5'd18, 5'd14, 5'd10, 5'd6, 5'd2, 5'd24,
    5'd20, 5'd16, 5'd12, 5'd8, 5'd4, 5'd0, 5'd22, 5'd18
  };
  localparam logic [LETTER_W-1:0] TAB_MID [16] = '{
    5'd0, 5'd16, 5'd6, 5'd22, 5'd12, 5'd2, 5'd18, 5'd8,
    5'd24, 5'd14, 5'd4, 5'd20, 5'd10, 5'd0, 5'd16, 5'd6
  };

  // One complete plaintext block; lanes at or beyond the block size are zero.
  typedef struct packed {
    logic [SIZE_W-1:0]                  size;
    logic [ROW_ENTRIES-1:0][LETTER_W-1:0] letter;
  } block_t;

  // Reduces a 12-bit sum modulo 26 from its three hex digits.
  function automatic logic [LETTER_W-1:0] mod26(input logic [SUM_W-1:0] s);
    logic [6:0] t;
    t = 7'(TAB_HI[s[11:8]]) + 7'(TAB_MID[s[7:4]]) + 7'(s[3:0]);
    if (t >= ALPHABET_2) begin
      t = t - ALPHABET_2;
    end else if (t >= ALPHABET) begin
      t = t - ALPHABET;
    end
    return t[LETTER_W-1:0];
  endfunction

endpackage

[hw/rtl/hill_cipher_encrypt_unit.sv]
// ----------------------------------------------------------------------------
// hill_cipher_encrypt_unit
// Hill cipher encryption: plaintext letters are grouped into blocks of
// key_size letters, and each block is multiplied by the key matrix mod 26.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Beat content
//  --------  ---------  -----------------------------------------------------
//  s_axis    in         tdata[4:0] plain_letter, tlast end_of_message
//  m_axis    out        tdata[4:0] cipher_letter, tlast last_of_block
//  cfg       in         cfg_index register number, cfg_data register value
//
//  One letter is taken per cycle while the block queue has room and one
//  ciphertext letter is sent per cycle while m_axis is ready, so a block of n
//  letters in gives n letters out at full rate. The first ciphertext letter of
//  a block passes the queue, the dot-product stage and the output register.
//  Reset clears the key to the identity with a block size of one and empties
//  the pipeline. A stall on m_axis backs up the output register, the
//  dot-product stage and then the two-block queue, and only then is s_axis
//  held off; the configuration channel is always ready.
//
module hill_cipher_encrypt_unit #(
  parameter int MAX_KEY_SIZE = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,  // [4:0] plain_letter
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [7:0]                       m_axis_tdata,  // [4:0] cipher_letter
  output logic                             m_axis_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hce_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hce_pkg::ROW_W-1:0]        cfg_data
);

  // A key row holds four entries, so blocks never exceed four letters.
  localparam int LANES = (MAX_KEY_SIZE < hce_pkg::ROW_ENTRIES) ?
                         MAX_KEY_SIZE : hce_pkg::ROW_ENTRIES;

  logic [hce_pkg::SIZE_W-1:0]   key_size;
  logic [hce_pkg::ROW_W-1:0]    key_row [hce_pkg::ROW_ENTRIES];
  logic [hce_pkg::SIZE_W-1:0]   size_eff;
  logic                         cfg_write;
  logic                         size_write;

  logic                         q_push;
  hce_pkg::block_t              q_data;
  logic                         q_full;
  logic                         q_pop;
  logic                         q_valid;
  hce_pkg::block_t              q_head;
  logic [hce_pkg::LETTER_W-1:0] out_letter;

  assign cfg_ready  = 1'b1;
  assign cfg_write  = cfg_valid && cfg_ready;
  assign size_write = cfg_write && cfg_index == hce_pkg::REG_KEY_SIZE;

  // Block size of zero acts as one; oversized values saturate.
  always_comb begin
    if (key_size == '0) begin
      size_eff = hce_pkg::SIZE_W'(1);
    end else if (key_size > hce_pkg::SIZE_W'(LANES)) begin
      size_eff = hce_pkg::SIZE_W'(LANES);
    end else begin
      size_eff = key_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_size   <= hce_pkg::SIZE_W'(1);
      key_row[0] <= hce_pkg::ROW_W'(1);
      key_row[1] <= hce_pkg::ROW_W'(32);
      key_row[2] <= hce_pkg::ROW_W'(1024);
      key_row[3] <= hce_pkg::ROW_W'(32768);
    end else if (cfg_write) begin
      case (cfg_index)
        hce_pkg::REG_KEY_SIZE:  key_size   <= cfg_data[hce_pkg::SIZE_W-1:0];
        hce_pkg::REG_KEY_ROW_0: key_row[0] <= cfg_data;
        hce_pkg::REG_KEY_ROW_1: key_row[1] <= cfg_data;
        hce_pkg::REG_KEY_ROW_2: key_row[2] <= cfg_data;
        hce_pkg::REG_KEY_ROW_3: key_row[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  hce_front #(
    .LANES (LANES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_letter (s_axis_tdata[hce_pkg::LETTER_W-1:0]),
    .in_last   (s_axis_tlast),
    .size      (size_eff),
    .restart   (size_write),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_data)
  );

  hce_block_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  hce_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_valid),
    .head       (q_head),
    .pop        (q_pop),
    .key_row    (key_row),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_letter (out_letter),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, out_letter};

endmodule

[hw/rtl/hce_front.sv]
// ----------------------------------------------------------------------------
// hce_front
// Collects plaintext letters into a block and hands complete blocks to the
// block queue; drops a partial block at end of message.
// ----------------------------------------------------------------------------
module hce_front #(
  parameter int LANES = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [hce_pkg::LETTER_W-1:0]        in_letter,
  input  logic                                in_last,
  input  logic [hce_pkg::SIZE_W-1:0]          size,
  input  logic                                restart,
  input  logic                                q_full,
  output logic                                q_push,
  output hce_pkg::block_t                     q_data
);

  logic [hce_pkg::IDX_W-1:0]    cnt;
  logic [hce_pkg::LETTER_W-1:0] buffer [LANES];
  logic                         accept;
  logic                         complete;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign complete = (hce_pkg::SIZE_W'(cnt) + 3'd1) == size;
  assign q_push   = accept && complete;

  always_comb begin
    q_data        = '0;
    q_data.size   = size;
    for (int i = 0; i < LANES; i++) begin
      if (hce_pkg::SIZE_W'(i) < size) begin
        q_data.letter[i] = (hce_pkg::IDX_W'(i) == cnt) ? in_letter : buffer[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (restart) begin
      cnt <= '0;
    end else if (accept) begin
      if (complete || in_last) begin
        cnt <= '0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < LANES; i++) begin
      if (accept && hce_pkg::IDX_W'(i) == cnt) begin
        buffer[i] <= in_letter;
      end
    end
  end

endmodule

[hw/rtl/hce_block_queue.sv]
// ----------------------------------------------------------------------------
// hce_block_queue
// Two-entry queue of complete plaintext blocks between front and back.
// ----------------------------------------------------------------------------
module hce_block_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  hce_pkg::block_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output hce_pkg::block_t head
);

  hce_pkg::block_t entry [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  assign full       = count == 2'd2;
  assign head_valid = count != 2'd0;
  assign head       = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule

[hw/rtl/hce_back.sv]
// ----------------------------------------------------------------------------
// hce_back
// Walks the key rows of the head block, one ciphertext letter per cycle unless
// the output stalls: a dot-product stage, then modulo-26 into the output register.
// ----------------------------------------------------------------------------
module hce_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          head_valid,
  input  hce_pkg::block_t               head,
  output logic                          pop,
  input  logic [hce_pkg::ROW_W-1:0]     key_row [hce_pkg::ROW_ENTRIES],
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hce_pkg::LETTER_W-1:0]  out_letter,
  output logic                          out_last
);

  logic [hce_pkg::IDX_W-1:0]  row;
  logic                       row_last;
  logic                       issue;
  logic                       a_load;
  logic                       b_load;
  logic                       a_valid;
  logic [hce_pkg::SUM_W-1:0]  a_sum;
  logic                       a_last;
  logic [hce_pkg::SUM_W-1:0]  dot;
  logic [hce_pkg::ROW_W-1:0]  sel_row;

  assign b_load   = !out_valid || out_ready;
  assign a_load   = !a_valid || b_load;
  assign issue    = head_valid && a_load;
  assign row_last = (hce_pkg::SIZE_W'(row) + 3'd1) == head.size;
  assign pop      = issue && row_last;
  assign sel_row  = key_row[row];

  always_comb begin
    dot = '0;
    for (int i = 0; i < hce_pkg::ROW_ENTRIES; i++) begin
      dot = dot + hce_pkg::SUM_W'(
                    hce_pkg::PROD_W'(sel_row[i*hce_pkg::LETTER_W +: hce_pkg::LETTER_W])
                    * hce_pkg::PROD_W'(head.letter[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row       <= '0;
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (issue) begin
        row <= row_last ? '0 : row + 1'b1;
      end
      if (a_load) begin
        a_valid <= issue;
      end
      if (b_load) begin
        out_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      a_sum  <= dot;
      a_last <= row_last;
    end
    if (b_load) begin
      out_letter <= hce_pkg::mod26(a_sum);
      out_last   <= a_last;
    end
  end

endmodule

[test/hill_cipher_encrypt_checker.sv]
// ----------------------------------------------------------------------------
// Hill cipher encryption checker
// Watches the letter, cipher and configuration channels. It keeps its own copy
// of the key and the open plaintext block, and works out the ciphertext beats
// that each accepted letter causes. It then compares every cipher beat with
// the oldest beat still expected.
// ----------------------------------------------------------------------------
module hill_cipher_encrypt_checker #(
  parameter int MAX_KEY_SIZE = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [4:0] plain_letter
  input  logic                          s_axis_tlast,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [7:0]                    m_axis_tdata,  // [4:0] cipher_letter
  input  logic                          m_axis_tlast,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [hce_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hce_pkg::ROW_W-1:0]     cfg_data,
  output int                            errors,
  output int                            pending
);
  import hce_pkg::*;

  typedef struct packed {
    logic [LETTER_W-1:0] letter;
    logic                last;
  } cipher_beat_t;

  cipher_beat_t        cipher_fifo[$];
  cipher_beat_t        head;
  cipher_beat_t        beat;
  logic [SIZE_W-1:0]   key_size;
  logic [ROW_W-1:0]    key_row [ROW_ENTRIES];
  logic [LETTER_W-1:0] plain_block [ROW_ENTRIES];
  int                  fill;
  int                  span;
  int                  acc;

  task automatic report(input string what, input int got, input int want);
    if (errors < 40) begin
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    end
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      key_size   = 3'd1;
      key_row[0] = 20'd1;
      key_row[1] = 20'd32;
      key_row[2] = 20'd1024;
      key_row[3] = 20'd32768;
      fill       = 0;
      errors     = 0;
      cipher_fifo.delete();
    end else begin
      // Results are matched before new expectations are queued, so a stray
      // beat can never pair with a letter accepted at the same edge.
      if (m_axis_tvalid && m_axis_tready) begin
        if (cipher_fifo.size() == 0) begin
          report("cipher beat with nothing expected", int'(m_axis_tdata), -1);
        end else begin
          head = cipher_fifo[0];
          cipher_fifo.delete(0);
          if (m_axis_tdata[LETTER_W-1:0] !== head.letter) begin
            report("cipher_letter", int'(m_axis_tdata[LETTER_W-1:0]), int'(head.letter));
          end
          if (m_axis_tlast !== head.last) begin
            report("last_of_block", int'(m_axis_tlast), int'(head.last));
          end
          if (m_axis_tdata[7:LETTER_W] !== '0) begin
            report("tdata padding", int'(m_axis_tdata[7:LETTER_W]), 0);
          end
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KEY_SIZE: begin
            key_size = cfg_data[SIZE_W-1:0];
            fill     = 0;
          end
          REG_KEY_ROW_0: key_row[0] = cfg_data;
          REG_KEY_ROW_1: key_row[1] = cfg_data;
          REG_KEY_ROW_2: key_row[2] = cfg_data;
          REG_KEY_ROW_3: key_row[3] = cfg_data;
          default: ;
        endcase
      end

      if (s_axis_tvalid && s_axis_tready) begin
        // Size zero acts as one; large sizes saturate to what a row can hold.
        span = (key_size == '0) ? 1 : int'(key_size);
        if (span > MAX_KEY_SIZE) span = MAX_KEY_SIZE;
        if (span > ROW_ENTRIES) span = ROW_ENTRIES;
        if (fill >= span) fill = 0;
        plain_block[fill] = s_axis_tdata[LETTER_W-1:0];
        fill++;
        if (fill < span) begin
          if (s_axis_tlast) fill = 0;
        end else begin
          for (int j = 0; j < span; j++) begin
            acc = 0;
            for (int i = 0; i < span; i++) begin
              acc += int'(key_row[j][i*LETTER_W +: LETTER_W]) * int'(plain_block[i]);
            end
            beat.letter = LETTER_W'(acc % int'(ALPHABET));
            beat.last   = (j == span - 1);
            cipher_fifo.insert(cipher_fifo.size(), beat);
          end
          fill = 0;
        end
      end
    end
    pending <= cipher_fifo.size();
  end

endmodule

[test/hill_cipher_encrypt_unit_tb.sv]
// ----------------------------------------------------------------------------
// Hill cipher encryption unit testbench
// Drives plaintext letters and key settings into the unit and lets a checker
// beside it predict and compare every ciphertext beat. A short directed part
// covers the corner cases of the key and the block handling; random phases
// with random keys, random messages and random back-pressure follow.
// ----------------------------------------------------------------------------
module hill_cipher_encrypt_unit_tb;
  import hce_pkg::*;

  // Roughly this many letters are sent before the run winds down.
  localparam int LETTER_TARGET = 420;
  // Quiet cycles allowed after the last expected beat before a register
  // write or the verdict, with a clear margin over the queue and pipeline.
  localparam int SETTLE_CYCLES = 12;
  // Cycles without any accepted beat before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 2000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata = '0;   // [4:0] plain_letter
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [7:0]           m_axis_tdata;        // [4:0] cipher_letter
  logic                 m_axis_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_KEY_SIZE;
  logic [ROW_W-1:0]     cfg_data = '0;

  int mismatches;
  int letters_pending;
  int letters_sent = 0;
  int quiet_cycles = 0;

  // When cleared, the matching side runs at full rate with no gaps.
  bit s_idle = 1'b1;
  bit m_idle = 1'b1;

  always #1 clk = ~clk;

  hill_cipher_encrypt_unit uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  hill_cipher_encrypt_checker cipher_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .errors        (mismatches),
    .pending       (letters_pending)
  );

  // Sends one letter beat. The valid line is only lowered when a gap is
  // drawn, so back-to-back beats keep it high without a glitch. The task
  // returns right after the edge at which the beat was taken.
  task automatic send_letter(input logic [LETTER_W-1:0] letter, input logic eom);
    int gap;
    gap = s_idle ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(8 - LETTER_W){1'b0}}, letter};
    s_axis_tlast  <= eom;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    letters_sent++;
  endtask

  // Writes one register and leaves valid high, so that a following write
  // continues without a bubble. cfg_done closes a burst of writes.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [ROW_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic cfg_done();
    cfg_valid <= 1'b0;
  endtask

  task automatic load_key(input logic [SIZE_W-1:0] size, input logic [ROW_W-1:0] r0,
                          input logic [ROW_W-1:0] r1, input logic [ROW_W-1:0] r2,
                          input logic [ROW_W-1:0] r3);
    cfg_write(REG_KEY_SIZE, ROW_W'(size));
    cfg_write(REG_KEY_ROW_0, r0);
    cfg_write(REG_KEY_ROW_1, r1);
    cfg_write(REG_KEY_ROW_2, r2);
    cfg_write(REG_KEY_ROW_3, r3);
    cfg_done();
  endtask

  // Holds the sender off until every expected cipher beat has arrived, then
  // lets the pipeline settle. A partial block may still be open afterwards;
  // it produces nothing, so the unit is idle for register writes.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (letters_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly random 20-bit rows, with the all-zero and all-ones keys mixed in.
  function automatic logic [ROW_W-1:0] pick_row();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return ROW_W'($urandom_range(0, (1 << ROW_W) - 1));
    endcase
  endfunction

  // Mostly legal block sizes; zero and the saturating sizes now and then.
  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return SIZE_W'($urandom_range(5, 7));
      default: return SIZE_W'($urandom_range(1, 4));
    endcase
  endfunction

  // Letters are mostly a to z; the codes above z still reach the unit.
  function automatic logic [LETTER_W-1:0] pick_letter();
    if ($urandom_range(0, 9) == 0) return LETTER_W'($urandom_range(26, 31));
    return LETTER_W'($urandom_range(0, 25));
  endfunction

  // The receiver draws a stall before each cipher beat it takes.
  initial begin
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = m_idle ? $urandom_range(0, 16) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
    end
  end

  // Any accepted beat on any channel shows progress; a long silence means
  // the unit has hung.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int msg_len;
    bit close_msg;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset key: identity with blocks of one letter. Each letter comes back
    // reduced modulo 26, including the codes above z, and an end of message
    // on a completing letter changes nothing.
    send_letter(5'd0, 1'b0);
    send_letter(5'd25, 1'b0);
    send_letter(5'd31, 1'b1);
    send_letter(5'd13, 1'b1);

    // Largest sums: every key entry and every letter at 31.
    drain();
    load_key(3'd4, '1, '1, '1, '1);
    repeat (3) send_letter(5'd31, 1'b0);
    send_letter(5'd31, 1'b1);

    // A size of seven saturates to four letters per block.
    drain();
    load_key(3'd7, pick_row(), pick_row(), pick_row(), pick_row());
    repeat (4) send_letter(pick_letter(), 1'b0);

    // A size of zero acts as one; the all-zero key gives all-zero text.
    drain();
    load_key(3'd0, '0, '0, '0, '0);
    send_letter(5'd20, 1'b0);
    send_letter(5'd7, 1'b1);

    // End of message on an open block drops it; the next block starts fresh
    // and is closed by an end of message on its completing letter.
    drain();
    load_key(3'd3, pick_row(), pick_row(), pick_row(), '0);
    send_letter(5'd4, 1'b0);
    send_letter(5'd9, 1'b1);
    send_letter(5'd1, 1'b0);
    send_letter(5'd2, 1'b0);
    send_letter(5'd3, 1'b1);

    // A size write while a block is open throws the open letters away.
    send_letter(5'd5, 1'b0);
    send_letter(5'd6, 1'b0);
    drain();
    cfg_write(REG_KEY_SIZE, ROW_W'(2));
    cfg_done();
    send_letter(5'd7, 1'b0);
    send_letter(5'd8, 1'b0);

    // A row write while a block is open takes effect for that block.
    send_letter(5'd10, 1'b0);
    drain();
    cfg_write(REG_KEY_ROW_1, pick_row());
    cfg_done();
    send_letter(5'd11, 1'b1);

    // Random phases. Each one starts from an idle unit, rewrites some of the
    // key and sends a few messages. Messages are usually closed by an end of
    // message, sometimes left open into the next one, and now and then carry
    // a stray end of message in the middle. Some phases run with no gaps on
    // one side or both.
    while (letters_sent < LETTER_TARGET) begin
      drain();
      if ($urandom_range(0, 3) != 0) cfg_write(REG_KEY_SIZE, ROW_W'(pick_size()));
      for (int r = 0; r < ROW_ENTRIES; r++) begin
        if ($urandom_range(0, 1) != 0) cfg_write(REG_KEY_ROW_0 + CFG_IDX_W'(r), pick_row());
      end
      cfg_done();
      s_idle = ($urandom_range(0, 2) != 0);
      m_idle = ($urandom_range(0, 2) != 0);
      repeat ($urandom_range(1, 3)) begin
        msg_len   = $urandom_range(1, 24);
        close_msg = ($urandom_range(0, 4) != 0);
        for (int k = 0; k < msg_len; k++) begin
          send_letter(pick_letter(),
                      (k == msg_len - 1 && close_msg) || ($urandom_range(0, 19) == 0));
        end
        // Occasionally let the whole pipeline run dry mid-phase.
        if ($urandom_range(0, 3) == 0) drain();
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/hce_pkg.sv
hw/rtl/hce_front.sv
hw/rtl/hce_block_queue.sv
hw/rtl/hce_back.sv
hw/rtl/hill_cipher_encrypt_unit.sv
test/hill_cipher_encrypt_checker.sv
test/hill_cipher_encrypt_unit_tb.sv
